// File: design/uris_pkg.sv
// Shared types and constants for the UART receive sampler.
// Frame phase encoding, register map and register reset values.
// No dependencies.
`default_nettype none

package uris_pkg;

   localparam int CFG_W  = 10;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_START_WINDOW  = 2'd0,
      REG_BIT_WINDOW    = 2'd1,
      REG_ONE_THRESHOLD = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   localparam logic [CFG_W-1:0] START_WINDOW_RST  = 10'd310;
   localparam logic [CFG_W-1:0] BIT_WINDOW_RST    = 10'd324;
   localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 10'd160;

endpackage

`default_nettype wire

// File: design/uart_rx_integrating_sampler.sv
// UART receive sampler: integrate-and-threshold bit decision, 8N1-style framing.
// Depends on uris_pkg for the phase type, register map and reset values.
`default_nettype none

// One line sample is taken per word on req; a received byte leaves on rsp
// when the stop level is seen. Each sample passes an input register and the
// counter and phase update; a byte goes on to the result register. A word is
// accepted every cycle except in the only stall: a byte waiting in the
// result register while the next stop sample arrives. Registers at 0x0
// start_window, 0x4 bit_window, 0x8 one_threshold, 10 bits each.
module uart_rx_integrating_sampler
   import uris_pkg::*;
#(
   parameter int COUNT_BITS = 10,
   parameter int DATA_BITS  = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [7:0]        req_tdata,   // [0] line_level, [7:1] zero
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] rx_byte
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire  [ADDR_W-1:0] csr_paddr,
   input  wire  [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int WW    = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
   localparam int IDX_W = $clog2(DATA_BITS + 1);
   localparam logic [WW-1:0] CountMax = WW'((64'd1 << COUNT_BITS) - 64'd1);

   // configuration
   logic [CFG_W-1:0] start_win_ff, bit_win_ff, threshold_ff;
   logic             csr_wr;
   reg_index_type    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_win_ff <= START_WINDOW_RST;
         bit_win_ff   <= BIT_WINDOW_RST;
         threshold_ff <= ONE_THRESHOLD_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_START_WINDOW:  start_win_ff <= csr_pwdata[CFG_W-1:0];
            REG_BIT_WINDOW:    bit_win_ff   <= csr_pwdata[CFG_W-1:0];
            REG_ONE_THRESHOLD: threshold_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_START_WINDOW:  csr_prdata = DATA_W'(start_win_ff);
         REG_BIT_WINDOW:    csr_prdata = DATA_W'(bit_win_ff);
         REG_ONE_THRESHOLD: csr_prdata = DATA_W'(threshold_ff);
         default:           csr_prdata = '0;
      endcase
   end

   function automatic logic [WW-1:0] eff_len(input logic [CFG_W-1:0] w);
      logic [WW-1:0] wx;
      wx = WW'(w);
      if (wx == '0)
         eff_len = WW'(1);
      else if (wx > CountMax)
         eff_len = CountMax;
      else
         eff_len = wx;
   endfunction

   // input register
   logic in_valid_ff, in_valid_in;
   logic level_ff, level_in;
   logic proc_go, emit;

   // frame state
   phase_type             phase_ff, phase_in;
   logic [IDX_W-1:0]      widx_ff, widx_in;
   logic [COUNT_BITS-1:0] scount_ff, scount_in;
   logic [COUNT_BITS-1:0] hcount_ff, hcount_in;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;

   logic [WW-1:0]         n_ext;
   logic [COUNT_BITS-1:0] hcount_nx;
   logic [IDX_W-1:0]      widx_nx;

   assign emit       = in_valid_ff && (phase_ff == PH_STOP) && level_ff;
   assign proc_go    = in_valid_ff && (!out_valid_ff || rsp_tready || !emit);
   assign req_tready = !in_valid_ff || proc_go;

   assign n_ext     = WW'(scount_ff) + WW'(1);
   assign hcount_nx = hcount_ff + COUNT_BITS'(level_ff);
   assign widx_nx   = widx_ff + IDX_W'(1);

   always_comb begin
      in_valid_in = in_valid_ff;
      level_in    = level_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         level_in    = req_tdata[0];
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      if (proc_go && emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = 8'(shift_ff);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      widx_in   = widx_ff;
      scount_in = scount_ff;
      hcount_in = hcount_ff;
      shift_in  = shift_ff;
      if (proc_go) begin
         case (phase_ff)
            PH_IDLE: begin
               if (!level_ff) begin
                  phase_in  = PH_START;
                  widx_in   = '0;
                  scount_in = '0;
                  hcount_in = '0;
                  shift_in  = '0;
               end
            end
            PH_START: begin
               if (n_ext >= eff_len(start_win_ff)) begin
                  phase_in  = PH_DATA;
                  widx_in   = '0;
                  scount_in = '0;
                  hcount_in = '0;
               end else begin
                  scount_in = n_ext[COUNT_BITS-1:0];
                  hcount_in = hcount_nx;
               end
            end
            PH_DATA: begin
               if (n_ext >= eff_len(bit_win_ff)) begin
                  if ((WW'(hcount_nx) > WW'(threshold_ff)) &&
                      (widx_ff < IDX_W'(DATA_BITS)))
                     shift_in = shift_ff | (DATA_BITS'(1) << widx_ff);
                  widx_in   = widx_nx;
                  scount_in = '0;
                  hcount_in = '0;
                  if (widx_nx >= IDX_W'(DATA_BITS))
                     phase_in = PH_STOP;
               end else begin
                  scount_in = n_ext[COUNT_BITS-1:0];
                  hcount_in = hcount_nx;
               end
            end
            default: begin
               if (level_ff) begin
                  phase_in  = PH_IDLE;
                  widx_in   = '0;
                  scount_in = '0;
                  hcount_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         widx_ff      <= '0;
         scount_ff    <= '0;
         hcount_ff    <= '0;
         shift_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         widx_ff      <= widx_in;
         scount_ff    <= scount_in;
         hcount_ff    <= hcount_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (scount_ff == '0) && (hcount_ff == '0))
      else $error("counters not clear while idle");

   a_high_le_samples: assert property (@(posedge clock) disable iff (reset)
      hcount_ff <= scount_ff)
      else $error("high count exceeds sample count");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (widx_ff < IDX_W'(DATA_BITS)))
      else $error("data window index out of range");

   a_byte_from_stop: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(phase_ff == PH_STOP && level_ff && in_valid_ff))
      else $error("byte produced outside stop phase");

endmodule

`default_nettype wire
